// ----- hdl/vfc_pkg.sv -----
// Shared types and constants for the VISCA frame classifier.
// Used by vfc_capture, vfc_classify, visca_frame_classifier_core and tb_top; no dependencies.

package vfc_pkg;

   localparam int MIN_LEN_DEFAULT    = 3;
   localparam int MAX_LEN_DEFAULT    = 16;
   localparam int BCAST_ADDR_DEFAULT = 8;

   localparam int BYTE_W      = 8;
   localparam int ADDR_SRC_W  = 3;
   localparam int ADDR_DST_W  = 4;
   localparam int FRAME_LEN_W = 5;
   localparam int RSP_DATA_W  = 32;

   // Byte values that the classification looks for.
   localparam logic [BYTE_W-1:0] TERM_BYTE       = 8'hFF;
   localparam logic [BYTE_W-1:0] ADDR_SET_HDR    = 8'h88;
   localparam logic [BYTE_W-1:0] ADDR_SET_CMD    = 8'h30;
   localparam logic [BYTE_W-1:0] INQ_CMD         = 8'h09;
   localparam logic [BYTE_W-1:0] NET_CHANGE_CMD  = 8'h38;
   localparam logic [BYTE_W-1:0] INQ_REPLY_BYTE  = 8'h50;
   localparam logic [BYTE_W-1:0] HI_ACK          = 8'h40;
   localparam logic [BYTE_W-1:0] HI_COMPLETION   = 8'h50;
   localparam logic [BYTE_W-1:0] HI_ERROR        = 8'h60;
   localparam logic [BYTE_W-1:0] HI_NIBBLE_MASK  = 8'hF0;
   localparam logic [ADDR_SRC_W-1:0] CTRL_ADDR   = 3'd0;

   typedef enum logic [2:0] {
      KIND_UNKNOWN     = 3'd0,
      KIND_ADDRESS_SET = 3'd1,
      KIND_COMMAND     = 3'd2,
      KIND_INQUIRY     = 3'd3,
      KIND_ACK         = 3'd4,
      KIND_COMPLETION  = 3'd5,
      KIND_ERROR       = 3'd6,
      KIND_NET_CHANGE  = 3'd7
   } msg_kind_type;

   typedef enum logic [1:0] {
      SOCKET_NONE = 2'd0,
      SOCKET_ONE  = 2'd1,
      SOCKET_TWO  = 2'd2
   } socket_type;

   // Snapshot of a finished frame, handed from capture to classify.
   typedef struct packed {
      logic [BYTE_W-1:0]      header_byte;
      logic [BYTE_W-1:0]      second_byte;
      logic [BYTE_W-1:0]      third_byte;
      logic                   ends_ff;
      logic                   len_in_bounds;
      logic                   len_ge2;
      logic                   len_ge3;
      logic                   len_ge4;
      logic                   len_eq3;
      logic                   len_eq4;
      logic [FRAME_LEN_W-1:0] frame_len;
   } snap_type;

   typedef struct packed {
      logic                   frame_ok;
      msg_kind_type           msg_kind;
      logic [ADDR_SRC_W-1:0]  src_addr;
      logic [ADDR_DST_W-1:0]  dst_addr;
      logic                   is_broadcast;
      socket_type             socket_num;
      logic                   has_error;
      logic [BYTE_W-1:0]      error_byte;
      logic                   inquiry_reply;
      logic [FRAME_LEN_W-1:0] frame_len;
   } result_type;

endpackage

// ----- hdl/visca_frame_classifier_core.sv -----
// Top level of the VISCA frame classifier: stream handshakes around capture and classify.
// Depends on vfc_pkg, vfc_capture and vfc_classify.
//
//   channel | dir | beat                       | fields (tdata/tuser from bit 0)
//   req_    | in  | one frame byte             | tdata: data_byte; tlast: end_of_frame
//   rsp_    | out | one result per frame       | tdata: see port list; tuser: msg_kind
//
// The block accepts one byte per cycle while req_tready is high. Once a frame's last
// byte is accepted, its result passes the snapshot register and then the result register.
// Reset clears the byte count and both valid flags; the captured bytes are not reset.
// A stalled result holds the snapshot stage; bytes keep flowing until the snapshot
// register is full and cannot move on, and only then is req_tready dropped.

module visca_frame_classifier_core
   import vfc_pkg::*;
#(
   parameter int MinLen    = MIN_LEN_DEFAULT,
   parameter int MaxLen    = MAX_LEN_DEFAULT,
   parameter int BcastAddr = BCAST_ADDR_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // end_of_frame

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] frame_ok, [3:1] src_addr, [7:4] dst_addr, [8] is_broadcast,
   // [10:9] socket_num, [11] has_error, [19:12] error_byte,
   // [20] inquiry_reply, [25:21] frame_len, [31:26] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]            rsp_tuser    // [2:0] msg_kind
);

   logic       accept;
   logic       snap_valid, snap_take;
   logic       rsp_free;
   snap_type   snap;
   result_type rsp;

   // The result register can load when it is empty or its beat leaves this cycle.
   assign rsp_free   = !rsp_tvalid || rsp_tready;
   assign snap_take  = snap_valid && rsp_free;
   assign req_tready = !snap_valid || rsp_free;
   assign accept     = req_tvalid && req_tready;

   vfc_capture #(
      .MinLen (MinLen),
      .MaxLen (MaxLen)
   ) u_capture (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_tdata),
      .end_of_frame (req_tlast),
      .snap_take    (snap_take),
      .snap_valid   (snap_valid),
      .snap         (snap)
   );

   vfc_classify #(
      .BcastAddr (BcastAddr)
   ) u_classify (
      .clock     (clock),
      .reset     (reset),
      .snap_take (snap_take),
      .snap      (snap),
      .rsp_take  (rsp_tvalid && rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp       (rsp)
   );

   assign rsp_tdata = {6'd0, rsp.frame_len, rsp.inquiry_reply, rsp.error_byte,
                       rsp.has_error, rsp.socket_num, rsp.is_broadcast,
                       rsp.dst_addr, rsp.src_addr, rsp.frame_ok};
   assign rsp_tuser = rsp.msg_kind;

   a_invalid_unknown: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.frame_ok |-> rsp.msg_kind == KIND_UNKNOWN)
      else $error("invalid frame carries a message kind");

   a_error_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.has_error |-> rsp.frame_len == FRAME_LEN_W'(4))
      else $error("error reply with a length other than four");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> snap_valid && rsp_tvalid && !rsp_tready)
      else $error("input stalled without a blocked result");

endmodule

// ----- hdl/vfc_capture.sv -----
// Byte counter, capture of the first three bytes and the frame snapshot register.
// Depends on vfc_pkg.

module vfc_capture
   import vfc_pkg::*;
#(
   parameter int MinLen = MIN_LEN_DEFAULT,
   parameter int MaxLen = MAX_LEN_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              end_of_frame,
   input  logic              snap_take,
   output logic              snap_valid,
   output snap_type          snap
);

   localparam int CNT_W = $clog2(MaxLen + 2);
   localparam logic [CNT_W-1:0] SAT_LEN = CNT_W'(MaxLen + 1);
   localparam logic [CNT_W-1:0] MIN_L   = CNT_W'(MinLen);
   localparam logic [CNT_W-1:0] MAX_L   = CNT_W'(MaxLen);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] hdr_ff, hdr_in, sec_ff, sec_in, thr_ff, thr_in;
   logic              snap_valid_ff, snap_valid_in;
   snap_type          snap_ff, snap_in;
   logic [CNT_W-1:0]  len;

   always_comb begin
      len    = (count_ff == SAT_LEN) ? SAT_LEN : count_ff + CNT_W'(1);
      hdr_in = (count_ff == CNT_W'(0)) ? data_byte : hdr_ff;
      sec_in = (count_ff == CNT_W'(1)) ? data_byte : sec_ff;
      thr_in = (count_ff == CNT_W'(2)) ? data_byte : thr_ff;
      count_in = end_of_frame ? CNT_W'(0) : len;

      snap_in.header_byte   = hdr_in;
      snap_in.second_byte   = sec_in;
      snap_in.third_byte    = thr_in;
      snap_in.ends_ff       = (data_byte == TERM_BYTE);
      snap_in.len_in_bounds = (len >= MIN_L) && (len <= MAX_L);
      snap_in.len_ge2       = (len >= CNT_W'(2));
      snap_in.len_ge3       = (len >= CNT_W'(3));
      snap_in.len_ge4       = (len >= CNT_W'(4));
      snap_in.len_eq3       = (len == CNT_W'(3));
      snap_in.len_eq4       = (len == CNT_W'(4));
      snap_in.frame_len     = FRAME_LEN_W'(len);

      if (accept && end_of_frame) begin
         snap_valid_in = 1'b1;
      end else if (snap_take) begin
         snap_valid_in = 1'b0;
      end else begin
         snap_valid_in = snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hdr_ff <= hdr_in;
         sec_ff <= sec_in;
         thr_ff <= thr_in;
         if (end_of_frame) begin
            snap_ff <= snap_in;
         end
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_frame |=> count_ff == CNT_W'(0))
      else $error("byte count not cleared after the last byte");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SAT_LEN)
      else $error("byte count passed its saturation value");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      snap_valid_ff && !snap_take |-> !accept)
      else $error("byte accepted while a pending snapshot is blocked");

endmodule

// ----- hdl/vfc_classify.sv -----
// Frame classification logic and the result register.
// Depends on vfc_pkg.

module vfc_classify
   import vfc_pkg::*;
#(
   parameter int BcastAddr = BCAST_ADDR_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       snap_take,
   input  snap_type   snap,
   input  logic       rsp_take,
   output logic       rsp_valid,
   output result_type rsp
);

   localparam logic [ADDR_DST_W-1:0] BCAST = ADDR_DST_W'(BcastAddr);

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;
   logic [BYTE_W-1:0] hi;
   logic [3:0]        lo;
   logic              ok, ack, comp, err, netc, inq;

   always_comb begin
      hi   = snap.len_ge2 ? (snap.second_byte & HI_NIBBLE_MASK) : '0;
      lo   = snap.second_byte[3:0];
      ok   = snap.len_in_bounds && snap.ends_ff && snap.header_byte[7];
      ack  = snap.len_eq3 && (hi == HI_ACK) && snap.ends_ff;
      comp = snap.len_ge3 && (hi == HI_COMPLETION) && snap.ends_ff;
      err  = snap.len_eq4 && (hi == HI_ERROR) && snap.ends_ff;
      netc = snap.len_eq3 && (snap.second_byte == NET_CHANGE_CMD) && snap.ends_ff;
      inq  = snap.len_ge4 && (snap.second_byte == INQ_REPLY_BYTE) && snap.ends_ff;

      rsp_in.frame_ok = ok;
      rsp_in.src_addr = snap.header_byte[6:4];
      rsp_in.dst_addr = snap.header_byte[3:0];

      rsp_in.msg_kind = KIND_UNKNOWN;
      if (ok) begin
         priority if (snap.header_byte == ADDR_SET_HDR && snap.len_eq4
                      && snap.second_byte == ADDR_SET_CMD) begin
            rsp_in.msg_kind = KIND_ADDRESS_SET;
         end else if (snap.header_byte[6:4] == CTRL_ADDR) begin
            rsp_in.msg_kind = (snap.second_byte == INQ_CMD) ? KIND_INQUIRY : KIND_COMMAND;
         end else if (ack) begin
            rsp_in.msg_kind = KIND_ACK;
         end else if (comp) begin
            rsp_in.msg_kind = KIND_COMPLETION;
         end else if (err) begin
            rsp_in.msg_kind = KIND_ERROR;
         end else if (netc) begin
            rsp_in.msg_kind = KIND_NET_CHANGE;
         end else begin
            rsp_in.msg_kind = KIND_UNKNOWN;
         end
      end

      // Reply frames carry the socket number in the low nibble of byte one.
      rsp_in.socket_num = SOCKET_NONE;
      if (hi == HI_ACK || hi == HI_COMPLETION || hi == HI_ERROR) begin
         if (lo == 4'd1) begin
            rsp_in.socket_num = SOCKET_ONE;
         end else if (lo == 4'd2) begin
            rsp_in.socket_num = SOCKET_TWO;
         end
      end

      rsp_in.is_broadcast  = (snap.header_byte[3:0] == BCAST);
      rsp_in.has_error     = err;
      rsp_in.error_byte    = err ? snap.third_byte : '0;
      rsp_in.inquiry_reply = inq;
      rsp_in.frame_len     = snap.frame_len;

      if (snap_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for visca_frame_classifier_core: frame bytes go in on the req_ stream,
// and each frame's classification from the rsp_ stream is checked against a local predictor.
// Depends on vfc_pkg and the classifier RTL.

module tb_top;
   import vfc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MIN_LEN        = MIN_LEN_DEFAULT;
   localparam int MAX_LEN        = MAX_LEN_DEFAULT;
   localparam int BCAST_ADDR     = BCAST_ADDR_DEFAULT;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_BYTES   = 470;

   typedef logic [BYTE_W-1:0] frame_bytes_type[$];

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]            rsp_tuser;

   // Predictor state: byte count of the frame in progress and its first three bytes.
   int                    frame_pos;
   logic [BYTE_W-1:0]     hdr_q;
   logic [BYTE_W-1:0]     cmd_q;
   logic [BYTE_W-1:0]     arg_q;

   result_type            frame_verdicts[$];
   int                    mismatch_count = 0;
   int                    bytes_sent     = 0;
   int                    quiet_cycles   = 0;
   bit                    idle_on        = 1'b1;
   int                    hold_asked     = 0;
   int                    hold_granted   = 0;
   int                    hold_left      = 0;
   int                    stall_left     = 0;

   visca_frame_classifier_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] data_byte
      .req_tlast  (req_tlast),   // end_of_frame
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [0] ok, [3:1] src, [7:4] dst, [8] bcast, [10:9] socket,
                                 // [11] error, [19:12] error byte, [20] inq reply, [25:21] len
      .rsp_tuser  (rsp_tuser)    // [2:0] msg_kind
   );

   always #5 clock = ~clock;

   // Classifies one accepted beat. Returns 1 when the beat closes a frame, with its verdict.
   function automatic bit classify_frame_byte(input logic [BYTE_W-1:0] data_byte,
                                              input logic end_of_frame,
                                              output result_type verdict);
      int                    len;
      logic                  ends_ff;
      logic                  len_ok;
      logic                  ack;
      logic                  comp;
      logic                  err;
      logic                  netc;
      logic                  inq;
      logic [BYTE_W-1:0]     hi;
      logic [3:0]            lo;
      logic [ADDR_SRC_W-1:0] src;
      logic [ADDR_DST_W-1:0] dst;
      msg_kind_type          kind;
      socket_type            sock;

      verdict = '0;
      if (frame_pos == 0) hdr_q = data_byte;
      else if (frame_pos == 1) cmd_q = data_byte;
      else if (frame_pos == 2) arg_q = data_byte;

      // The count saturates one past the longest legal frame.
      len = frame_pos + 1;
      if (len > MAX_LEN + 1) len = MAX_LEN + 1;
      if (!end_of_frame) begin
         frame_pos = len;
         return 1'b0;
      end
      frame_pos = 0;

      ends_ff = (data_byte == TERM_BYTE);
      len_ok  = (len >= MIN_LEN) && (len <= MAX_LEN);
      src     = hdr_q[6:4];
      dst     = hdr_q[3:0];
      hi      = (len >= 2) ? (cmd_q & HI_NIBBLE_MASK) : 8'h00;
      lo      = cmd_q[3:0];

      ack  = (len == 3) && (hi == HI_ACK) && ends_ff;
      comp = (len >= 3) && ends_ff && (hi == HI_COMPLETION);
      err  = (len == 4) && (hi == HI_ERROR) && ends_ff;
      netc = (len == 3) && (cmd_q == NET_CHANGE_CMD) && ends_ff;
      inq  = (len >= 4) && (cmd_q == INQ_REPLY_BYTE) && ends_ff;

      verdict.frame_ok = len_ok && ends_ff && hdr_q[7];

      // Kind priority: address set, then controller frames, then the reply types.
      kind = KIND_UNKNOWN;
      if (verdict.frame_ok) begin
         if (hdr_q == ADDR_SET_HDR && len == 4 && cmd_q == ADDR_SET_CMD) kind = KIND_ADDRESS_SET;
         else if (src == CTRL_ADDR) kind = (cmd_q == INQ_CMD) ? KIND_INQUIRY : KIND_COMMAND;
         else if (ack) kind = KIND_ACK;
         else if (comp) kind = KIND_COMPLETION;
         else if (err) kind = KIND_ERROR;
         else if (netc) kind = KIND_NET_CHANGE;
      end

      sock = SOCKET_NONE;
      if (len >= 2 && (hi == HI_ACK || hi == HI_COMPLETION || hi == HI_ERROR)) begin
         if (lo == 4'd1) sock = SOCKET_ONE;
         else if (lo == 4'd2) sock = SOCKET_TWO;
      end

      verdict.msg_kind      = kind;
      verdict.src_addr      = src;
      verdict.dst_addr      = dst;
      verdict.is_broadcast  = (dst == BCAST_ADDR[ADDR_DST_W-1:0]);
      verdict.socket_num    = sock;
      verdict.has_error     = err;
      verdict.error_byte    = err ? arg_q : 8'h00;
      verdict.inquiry_reply = inq;
      verdict.frame_len     = len[FRAME_LEN_W-1:0];
      return 1'b1;
   endfunction

   // Offers one beat, waits for the handshake, then updates the predictor.
   task automatic send_byte(input logic [BYTE_W-1:0] data_byte, input logic end_of_frame);
      result_type verdict;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data_byte;
      req_tlast  <= end_of_frame;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      if (classify_frame_byte(data_byte, end_of_frame, verdict)) begin
         frame_verdicts = {frame_verdicts, verdict};
      end
   endtask

   task automatic send_frame(input frame_bytes_type frame);
      for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
   endtask

   // Mostly well-formed frames with random content; the rest are malformed or odd lengths.
   task automatic send_random_frame(input int max_len);
      frame_bytes_type   frame;
      int                len;
      logic [BYTE_W-1:0] hdr;
      logic [BYTE_W-1:0] cmd;
      logic [3:0]        lo;
      int                pick;

      pick = $urandom_range(0, 9);
      if (pick < 4) len = 3;
      else if (pick < 7) len = 4;
      else len = $urandom_range(1, max_len);

      case ($urandom_range(0, 5))
         0: hdr = BYTE_W'($urandom_range(0, 255));
         1: hdr = 8'h80 | BYTE_W'($urandom_range(0, 15));      // controller source
         2: hdr = ADDR_SET_HDR;
         default: hdr = 8'h80 | BYTE_W'($urandom_range(0, 127));
      endcase

      case ($urandom_range(0, 2))
         0: lo = 4'd1;
         1: lo = 4'd2;
         default: lo = 4'($urandom_range(0, 15));
      endcase

      case ($urandom_range(0, 8))
         0: cmd = ADDR_SET_CMD;
         1: cmd = INQ_CMD;
         2: cmd = NET_CHANGE_CMD;
         3: cmd = INQ_REPLY_BYTE;
         4: cmd = HI_ACK | lo;
         5: cmd = HI_COMPLETION | lo;
         6: cmd = HI_ERROR | lo;
         default: cmd = BYTE_W'($urandom_range(0, 255));
      endcase

      for (int i = 0; i < len; i++) begin
         if (i == len - 1) frame = {frame, (($urandom_range(0, 9) != 0) ? TERM_BYTE :
                                            BYTE_W'($urandom_range(0, 255)))};
         else if (i == 0) frame = {frame, hdr};
         else if (i == 1) frame = {frame, cmd};
         else frame = {frame, BYTE_W'($urandom_range(0, 255))};
      end
      send_frame(frame);
   endtask

   task automatic test_message_kinds();
      // The first frame fills all three captured bytes before anything reads them.
      send_frame('{ADDR_SET_HDR, ADDR_SET_CMD, 8'h01, TERM_BYTE});
      send_frame('{8'h81, 8'h01, TERM_BYTE});                // controller command
      send_frame('{8'h81, INQ_CMD, TERM_BYTE});              // controller inquiry
      send_frame('{8'h90, HI_ACK | 8'h01, TERM_BYTE});       // ack, socket one
      send_frame('{8'hF8, HI_COMPLETION | 8'h02, TERM_BYTE}); // completion, broadcast dest
      send_frame('{8'h90, HI_ERROR | 8'h01, 8'h41, TERM_BYTE});
      send_frame('{8'h90, NET_CHANGE_CMD, TERM_BYTE});
      send_frame('{8'hA0, INQ_REPLY_BYTE, 8'h00, TERM_BYTE}); // inquiry reply
   endtask

   task automatic test_short_and_invalid();
      send_frame('{TERM_BYTE});                  // one byte: too short, no socket
      send_frame('{8'h9F, TERM_BYTE});           // two bytes
      send_frame('{8'h10, 8'h41, TERM_BYTE});    // header bit 7 clear: unknown kind
      send_frame('{8'h90, 8'h41, 8'h00});        // missing terminator
   endtask

   task automatic test_random_frames();
      while (bytes_sent < RANDOM_BYTES) send_random_frame(MAX_LEN + 4);
   endtask

   // The receiver holds off while short frames keep coming, so the input must stall.
   task automatic test_backpressure();
      hold_asked++;
      repeat (12) send_random_frame(4);
   endtask

   task automatic test_full_rate();
      idle_on = 1'b0;
      repeat (15) send_random_frame(6);
   endtask

   // Result side: random stalls, plus the long hold-off when a test asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_asked != hold_granted) begin
         hold_granted = hold_asked;
         hold_left    = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(input string field_name, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field_name, want, got);
      end
   endtask

   // Each result beat is compared with the oldest predicted verdict.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (frame_verdicts.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual tdata 0x%0h tuser 0x%0h",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = frame_verdicts.pop_front();
            check_field("frame_ok", want.frame_ok, rsp_tdata[0]);
            check_field("msg_kind", want.msg_kind, rsp_tuser);
            check_field("src_addr", want.src_addr, rsp_tdata[3:1]);
            check_field("dst_addr", want.dst_addr, rsp_tdata[7:4]);
            check_field("is_broadcast", want.is_broadcast, rsp_tdata[8]);
            check_field("socket_num", want.socket_num, rsp_tdata[10:9]);
            check_field("has_error", want.has_error, rsp_tdata[11]);
            check_field("error_byte", want.error_byte, rsp_tdata[19:12]);
            check_field("inquiry_reply", want.inquiry_reply, rsp_tdata[20]);
            check_field("frame_len", want.frame_len, rsp_tdata[25:21]);
            check_field("tdata padding", 0, rsp_tdata[31:26]);
         end
      end
   end

   // Watchdog: too many cycles without a beat on either side ends the run.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      frame_pos = 0;
      hdr_q     = '0;
      cmd_q     = '0;
      arg_q     = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_message_kinds();
      test_short_and_invalid();
      test_random_frames();
      test_backpressure();
      test_full_rate();
      req_tvalid <= 1'b0;

      // Drain, then allow the two-stage pipeline to show any stray result.
      while (frame_verdicts.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/vfc_pkg.sv
hdl/vfc_capture.sv
hdl/vfc_classify.sv
hdl/visca_frame_classifier_core.sv
sim/tb_top.sv
